// ===== rtl/yuyv_to_rgb565_framebuffer_writer_top_defines.svh =====
// assertion macros shared by the framebuffer writer rtl
`ifndef YUYV_TO_RGB565_FRAMEBUFFER_WRITER_TOP_DEFINES_SVH
`define YUYV_TO_RGB565_FRAMEBUFFER_WRITER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define YRFW_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("yrfw assertion failed");
// expression must never be true outside reset
`define YRFW_ASSERT_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("yrfw forbidden condition seen");
`else
`define YRFW_ASSERT(label, clk, rst_n, prop)
`define YRFW_ASSERT_NEVER(label, clk, rst_n, expr)
`endif

`endif

// ===== rtl/yrfw_pkg.sv =====
// types and constants for the yuyv to rgb565 framebuffer writer
package yrfw_pkg;

    localparam int CFG_W     = 13;
    localparam int CFG_IDX_W = 2;
    localparam int ADDR_W    = 24;
    localparam int PIX_W     = 16;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;

    localparam logic [CFG_W-1:0] IMAGE_WIDTH_RESET  = 13'd800;
    localparam logic [CFG_W-1:0] SCREEN_WIDTH_RESET = 13'd800;
    localparam logic [CFG_W-1:0] IMAGE_HEIGHT_RESET = 13'd600;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH  = 2'd0,
        CFG_SCREEN_WIDTH = 2'd1,
        CFG_IMAGE_HEIGHT = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic [7:0] luma_first;
        logic [7:0] chroma_blue;
        logic [7:0] luma_second;
        logic [7:0] chroma_red;
    } pix_beat_t;

    typedef struct packed {
        logic [ADDR_W-1:0] pixel_address;
        logic [PIX_W-1:0]  first_pixel;
        logic [PIX_W-1:0]  second_pixel;
        logic              frame_done;
    } rgb_beat_t;

    // placement of one macropixel as decided by the address walker
    typedef struct packed {
        logic              visible;
        logic [ADDR_W-1:0] address;
        logic              frame_done;
    } place_t;

    typedef struct packed {
        logic [FIFO_AW:0] count;
        logic             full;
    } fifo_status_t;

endpackage

// ===== rtl/yrfw_lane.sv =====
// one conversion lane: luma plus shared chroma to rgb565, two register stages
module yrfw_lane (
    input  logic                        clk,
    input  logic [7:0]                  luma,
    input  logic [7:0]                  chroma_blue,
    input  logic [7:0]                  chroma_red,
    output logic [yrfw_pkg::PIX_W-1:0]  pixel
);
    import yrfw_pkg::*;

    localparam int SW = 20;

    logic signed [8:0]    d;
    logic signed [8:0]    e;
    logic signed [SW-1:0] c_next, cr_next, gd_next, ge_next, bd_next;
    logic signed [SW-1:0] c_reg, cr_reg, gd_reg, ge_reg, bd_reg;
    logic signed [SW-1:0] r_sum, g_sum, b_sum;
    logic [7:0]           r_byte, g_byte, b_byte;
    logic [PIX_W-1:0]     pixel_next, pixel_reg;

    function automatic logic [7:0] to_byte(input logic signed [SW-1:0] v);
        logic [7:0] res;
        if (v[SW-1])
        begin
            res = 8'd0;
        end
        else if (|v[SW-2:16])
        begin
            res = 8'd255;
        end
        else
        begin
            res = v[15:8];
        end
        return res;
    endfunction

    // chroma bytes carry an offset of 128
    assign d = $signed({1'b0, chroma_blue} - 9'd128);
    assign e = $signed({1'b0, chroma_red} - 9'd128);

    assign c_next  = $signed({12'd0, luma}) * 20'sd298;
    assign cr_next = SW'(e) * 20'sd409;
    assign gd_next = SW'(d) * 20'sd100;
    assign ge_next = SW'(e) * 20'sd208;
    assign bd_next = SW'(d) * 20'sd516;

    always_ff @(posedge clk)
    begin
        c_reg  <= c_next;
        cr_reg <= cr_next;
        gd_reg <= gd_next;
        ge_reg <= ge_next;
        bd_reg <= bd_next;
    end

    assign r_sum = c_reg + cr_reg + 20'sd128;
    assign g_sum = c_reg - gd_reg - ge_reg + 20'sd128;
    assign b_sum = c_reg + bd_reg + 20'sd128;

    assign r_byte = to_byte(r_sum);
    assign g_byte = to_byte(g_sum);
    assign b_byte = to_byte(b_sum);

    assign pixel_next = {r_byte[7:3], g_byte[7:2], b_byte[7:3]};

    always_ff @(posedge clk)
    begin
        pixel_reg <= pixel_next;
    end

    assign pixel = pixel_reg;

endmodule

// ===== rtl/yrfw_addr_gen.sv =====
// column, row and framebuffer address walker
module yrfw_addr_gen #(
    parameter int MAX_DIMENSION = 4096
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        advance,
    input  logic [yrfw_pkg::CFG_W-1:0]  image_width,
    input  logic [yrfw_pkg::CFG_W-1:0]  screen_width,
    input  logic [yrfw_pkg::CFG_W-1:0]  image_height,
    output yrfw_pkg::place_t            place
);
    import yrfw_pkg::*;

    localparam int CW = $clog2(MAX_DIMENSION);
    localparam int DW = $clog2(MAX_DIMENSION + 1);
    localparam int XW = ((DW > CFG_W) ? DW : CFG_W) + 2;

    logic [CW-1:0]     column_reg, column_next;
    logic [CW-1:0]     row_reg, row_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic [XW-1:0]     w, sw, h;
    logic [XW-1:0]     col_x, row_x;
    logic              line_end, last_row, visible, last_visible;

    function automatic logic [XW-1:0] clamp_dim(input logic [CFG_W-1:0] v,
                                                 input logic [XW-1:0] lo);
        logic [XW-1:0] vx;
        logic [XW-1:0] res;
        vx = XW'(v);
        if (vx < lo)
        begin
            res = lo;
        end
        else if (vx > XW'(MAX_DIMENSION))
        begin
            res = XW'(MAX_DIMENSION);
        end
        else
        begin
            res = vx;
        end
        return res;
    endfunction

    assign w  = clamp_dim(image_width, XW'(2));
    assign sw = clamp_dim(screen_width, XW'(2));
    assign h  = clamp_dim(image_height, XW'(1));

    assign col_x = XW'(column_reg);
    assign row_x = XW'(row_reg);

    assign line_end     = (col_x + XW'(2)) >= w;
    assign last_row     = (row_x + XW'(1)) >= h;
    assign visible      = col_x < sw;
    assign last_visible = line_end || ((col_x + XW'(2)) >= sw);

    assign place.visible    = visible;
    assign place.address    = addr_reg;
    assign place.frame_done = last_row && last_visible;

    always_comb
    begin
        column_next = column_reg;
        row_next    = row_reg;
        addr_next   = addr_reg;
        if (advance)
        begin
            if (line_end)
            begin
                column_next = '0;
                if (last_row)
                begin
                    row_next  = '0;
                    addr_next = '0;
                end
                else
                begin
                    row_next  = row_reg + CW'(1);
                    // skip the screen padding at the end of the line
                    addr_next = addr_reg - ADDR_W'(column_reg) + ADDR_W'(sw);
                end
            end
            else
            begin
                column_next = column_reg + CW'(2);
                addr_next   = addr_reg + ADDR_W'(2);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_reg <= '0;
            row_reg    <= '0;
            addr_reg   <= '0;
        end
        else
        begin
            column_reg <= column_next;
            row_reg    <= row_next;
            addr_reg   <= addr_next;
        end
    end

endmodule

// ===== rtl/yrfw_merge_fifo.sv =====
// merges lane pixels with placement and queues finished beats for output
module yrfw_merge_fifo (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    input  logic [yrfw_pkg::ADDR_W-1:0]  address,
    input  logic                         frame_done,
    input  logic [yrfw_pkg::PIX_W-1:0]   lane0_pixel,
    input  logic [yrfw_pkg::PIX_W-1:0]   lane1_pixel,
    output logic                         rgb_valid,
    input  logic                         rgb_stall,
    output yrfw_pkg::rgb_beat_t          rgb_data,
    output yrfw_pkg::fifo_status_t       status
);
    import yrfw_pkg::*;

    rgb_beat_t        mem_reg [FIFO_DEPTH];
    rgb_beat_t        merged;
    logic [FIFO_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_AW:0]   count_reg, count_next;
    logic               pop;

    assign merged.pixel_address = address;
    assign merged.first_pixel   = lane0_pixel;
    assign merged.second_pixel  = lane1_pixel;
    assign merged.frame_done    = frame_done;

    assign rgb_valid = (count_reg != '0);
    assign rgb_data  = mem_reg[rd_ptr_reg];
    assign pop       = rgb_valid && !rgb_stall;

    assign status.count = count_reg;
    assign status.full  = (count_reg == (FIFO_AW+1)'(FIFO_DEPTH));

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + FIFO_AW'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + FIFO_AW'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + (FIFO_AW+1)'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - (FIFO_AW+1)'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= merged;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== rtl/yuyv_to_rgb565_framebuffer_writer_top.sv =====
// top level of the yuyv to rgb565 framebuffer writer
//
// usage:
// - pix channel (pix_valid / pix_stall / pix_data) takes one yuyv macropixel
//   per beat; a beat is taken on a clock edge with pix_valid high, pix_stall low
// - rgb channel (rgb_valid / rgb_stall / rgb_data) gives the framebuffer
//   address and both rgb565 pixels; a beat leaves when rgb_valid is high and
//   rgb_stall low; macropixels beyond the screen width give no beat
// - cfg channel (cfg_valid / cfg_ready / cfg_index / cfg_data) writes image
//   width, screen width and image height; cfg_ready is always high, write
//   only while no macropixel is in flight
// - path: an accepted beat passes the multiply stage, the pack stage, then the
//   write into the merge queue before it is presented on rgb
// - throughput: one macropixel per clock while pix_stall is low, set by the two
//   conversion lanes running in parallel and an address walker that steps per beat
// - reset clears counters, address and queue; registers return to 800x600
// - under rgb_stall a four-entry merge queue absorbs beats; pix_stall rises
//   once queued plus in-flight beats reach four, and comes from registers only
`include "yuyv_to_rgb565_framebuffer_writer_top_defines.svh"

module yuyv_to_rgb565_framebuffer_writer_top #(
    parameter int MAX_DIMENSION = 4096
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             pix_valid,
    output logic                             pix_stall,
    input  yrfw_pkg::pix_beat_t              pix_data,
    output logic                             rgb_valid,
    input  logic                             rgb_stall,
    output yrfw_pkg::rgb_beat_t              rgb_data,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [yrfw_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [yrfw_pkg::CFG_W-1:0]       cfg_data
);
    import yrfw_pkg::*;

    localparam int OCC_W = FIFO_AW + 2;

    // configuration registers
    logic [CFG_W-1:0] image_width_reg, screen_width_reg, image_height_reg;

    // placement of the current macropixel
    place_t place;
    logic   pix_accept;

    // placement pipeline, aligned with the lane stages
    logic              s1_valid_reg, s2_valid_reg;
    logic [ADDR_W-1:0] s1_addr_reg, s2_addr_reg;
    logic              s1_done_reg, s2_done_reg;

    logic [PIX_W-1:0] lane0_pixel, lane1_pixel;
    fifo_status_t     fifo_status;
    logic [OCC_W-1:0] occupancy;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= IMAGE_WIDTH_RESET;
            screen_width_reg <= SCREEN_WIDTH_RESET;
            image_height_reg <= IMAGE_HEIGHT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_IMAGE_WIDTH:  image_width_reg  <= cfg_data;
                CFG_SCREEN_WIDTH: screen_width_reg <= cfg_data;
                CFG_IMAGE_HEIGHT: image_height_reg <= cfg_data;
                default:          ;  // unused index, write dropped
            endcase
        end
    end

    // queued beats plus visible beats still in the lanes
    assign occupancy = OCC_W'(fifo_status.count) + OCC_W'(s1_valid_reg)
                     + OCC_W'(s2_valid_reg);
    assign pix_stall  = (occupancy >= OCC_W'(FIFO_DEPTH));
    assign pix_accept = pix_valid && !pix_stall;

    yrfw_addr_gen #(
        .MAX_DIMENSION (MAX_DIMENSION)
    ) u_addr_gen (
        .clk          (clk),
        .rst_n        (rst_n),
        .advance      (pix_accept),
        .image_width  (image_width_reg),
        .screen_width (screen_width_reg),
        .image_height (image_height_reg),
        .place        (place)
    );

    // lane 0 converts the first luma, lane 1 the second, chroma shared
    yrfw_lane u_lane0 (
        .clk         (clk),
        .luma        (pix_data.luma_first),
        .chroma_blue (pix_data.chroma_blue),
        .chroma_red  (pix_data.chroma_red),
        .pixel       (lane0_pixel)
    );

    yrfw_lane u_lane1 (
        .clk         (clk),
        .luma        (pix_data.luma_second),
        .chroma_blue (pix_data.chroma_blue),
        .chroma_red  (pix_data.chroma_red),
        .pixel       (lane1_pixel)
    );

    // valid bits carry only beats that will produce a result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= pix_accept && place.visible;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_addr_reg <= place.address;
        s1_done_reg <= place.frame_done;
        s2_addr_reg <= s1_addr_reg;
        s2_done_reg <= s1_done_reg;
    end

    yrfw_merge_fifo u_merge_fifo (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (s2_valid_reg),
        .address     (s2_addr_reg),
        .frame_done  (s2_done_reg),
        .lane0_pixel (lane0_pixel),
        .lane1_pixel (lane1_pixel),
        .rgb_valid   (rgb_valid),
        .rgb_stall   (rgb_stall),
        .rgb_data    (rgb_data),
        .status      (fifo_status)
    );

    // the lanes never push into a full queue
    `YRFW_ASSERT_NEVER(a_push_full, clk, rst_n, s2_valid_reg && fifo_status.full)
    // credit accounting never overcommits the queue
    `YRFW_ASSERT(a_occupancy, clk, rst_n, occupancy <= OCC_W'(FIFO_DEPTH))
    // a visible macropixel enters the lane pipeline on the next cycle
    `YRFW_ASSERT(a_visible_enters, clk, rst_n, (pix_accept && place.visible) |=> s1_valid_reg)

endmodule

// ===== verif/yuyv_to_rgb565_framebuffer_writer_top_test.sv =====
// self-checking testbench for the yuyv to rgb565 framebuffer writer top level
`timescale 1ns / 100ps

module yuyv_to_rgb565_framebuffer_writer_top_test;

    import yrfw_pkg::*;

    // index 3 is decoded by nobody, a write there must leave everything alone
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_INDEX = 2'd3;

    localparam int MAX_DIM        = 4096;
    localparam int QUIET_LIMIT    = 3000;   // cycles with no beat on any channel
    localparam int SETTLE_CYCLES  = 8;      // pipeline depth is three, plus margin
    localparam int RANDOM_PHASES  = 8;
    localparam int ITEMS_PER_PHASE = 70;

    // idle percentages per phase: none, sender only, receiver only, both
    localparam int GAP_BY_MODE[4]   = '{0, 50, 0, 18};
    localparam int STALL_BY_MODE[4] = '{0, 0, 50, 18};

    // one line of the directed script: either a register write or a macropixel,
    // with the result typed in where it is obvious
    typedef struct {
        bit                   is_register;
        logic [CFG_IDX_W-1:0] index;
        logic [CFG_W-1:0]     value;
        pix_beat_t            beat;
        bit                   checked;
        rgb_beat_t            result;
    } script_row_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 pix_valid = 1'b0;
    logic                 pix_stall;
    pix_beat_t            pix_data = '0;
    logic                 rgb_valid;
    logic                 rgb_stall = 1'b0;
    rgb_beat_t            rgb_data;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data = '0;

    // shadow of the block: registers as written, walker state
    logic [CFG_W-1:0]  image_width_reg  = IMAGE_WIDTH_RESET;
    logic [CFG_W-1:0]  screen_width_reg = SCREEN_WIDTH_RESET;
    logic [CFG_W-1:0]  image_height_reg = IMAGE_HEIGHT_RESET;
    logic [11:0]       walk_column  = '0;
    logic [11:0]       walk_row     = '0;
    logic [ADDR_W-1:0] walk_address = '0;

    rgb_beat_t   framebuffer_writes[$];   // rgb beats still owed by the block
    script_row_t script[$];
    int          gap_pct = 0;
    int          stall_pct = 0;
    int          mismatches = 0;
    int          quiet_cycles = 0;

    yuyv_to_rgb565_framebuffer_writer_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix_valid (pix_valid),
        .pix_stall (pix_stall),
        .pix_data  (pix_data),
        .rgb_valid (rgb_valid),
        .rgb_stall (rgb_stall),
        .rgb_data  (rgb_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #10 clk = ~clk;

    // ------------------------------------------------------------------
    // color conversion and address walk
    // ------------------------------------------------------------------

    // registers outside their range are used clamped to [lo, MAX_DIM]
    function automatic int clamp_dimension(input logic [CFG_W-1:0] raw, input int lo);
        int v;
        v = int'(raw);
        if (v < lo)
            return lo;
        if (v > MAX_DIM)
            return MAX_DIM;
        return v;
    endfunction

    // sum already carries the rounding term; floor shift then clip to a byte
    function automatic logic [7:0] clip_channel(input int sum);
        int v;
        if (sum < 0)
            return 8'd0;
        v = sum >>> 8;
        if (v > 255)
            return 8'd255;
        return v[7:0];
    endfunction

    // bt.601 integer conversion of one luma with the shared chroma offsets
    function automatic logic [PIX_W-1:0] rgb565_of(input logic [7:0] luma, input int cb,
                                                   input int cr);
        int         scaled;
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        scaled = 298 * int'(luma) + 128;
        r = clip_channel(scaled + 409 * cr);
        g = clip_channel(scaled - 100 * cb - 208 * cr);
        b = clip_channel(scaled + 516 * cb);
        return {r[7:3], g[7:2], b[7:3]};
    endfunction

    // places one macropixel in the framebuffer and steps the walker;
    // emits is low when the column lies at or past the screen width
    task automatic place_macropixel(input pix_beat_t beat, output bit emits,
                                    output rgb_beat_t placed);
        int  line_w;
        int  pitch;
        int  lines;
        int  column;
        int  cb;
        int  cr;
        bit  line_end;
        bit  last_row;
        line_w   = clamp_dimension(image_width_reg, 2);
        pitch    = clamp_dimension(screen_width_reg, 2);
        lines    = clamp_dimension(image_height_reg, 1);
        column   = int'(walk_column);
        cb       = int'(beat.chroma_blue) - 128;
        cr       = int'(beat.chroma_red) - 128;
        line_end = column + 2 >= line_w;
        last_row = int'(walk_row) + 1 >= lines;
        emits    = column < pitch;
        placed   = '0;
        if (emits)
        begin
            placed.pixel_address = walk_address;
            placed.first_pixel   = rgb565_of(beat.luma_first, cb, cr);
            placed.second_pixel  = rgb565_of(beat.luma_second, cb, cr);
            placed.frame_done    = last_row && (line_end || column + 2 >= pitch);
        end
        if (line_end)
        begin
            if (last_row)
            begin
                walk_row     = '0;
                walk_address = '0;
            end
            else
            begin
                walk_row     = walk_row + 12'd1;
                // back to the line start, then one pitch down (skips the padding)
                walk_address = walk_address - ADDR_W'(column) + ADDR_W'(pitch);
            end
            walk_column = '0;
        end
        else
        begin
            walk_column  = walk_column + 12'd2;
            walk_address = walk_address + ADDR_W'(2);
        end
    endtask

    // ------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------

    // one macropixel beat; valid stays high afterwards so back-to-back beats
    // need no second assignment in the same step
    task automatic send_macropixel(input pix_beat_t beat, input bit checked,
                                   input rgb_beat_t given);
        bit        emits;
        rgb_beat_t placed;
        cfg_valid <= 1'b0;
        while ($urandom_range(0, 99) < gap_pct)
        begin
            pix_valid <= 1'b0;
            @(posedge clk);
        end
        pix_valid <= 1'b1;
        pix_data  <= beat;
        @(posedge clk);
        while (pix_stall)
            @(posedge clk);
        place_macropixel(beat, emits, placed);
        if (emits)
            framebuffer_writes.push_back(checked ? given : placed);
    endtask

    // register write; cfg_valid is lowered by whoever drives next
    task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                  input logic [CFG_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (index)
            CFG_IMAGE_WIDTH:  image_width_reg  = value;
            CFG_SCREEN_WIDTH: screen_width_reg = value;
            CFG_IMAGE_HEIGHT: image_height_reg = value;
            default: ;
        endcase
    endtask

    // wait for every owed beat, then for beats that give no result to leave
    task automatic drain_pipeline();
        pix_valid <= 1'b0;
        cfg_valid <= 1'b0;
        while (framebuffer_writes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    function automatic script_row_t item_row(input logic [7:0] y0, input logic [7:0] u,
                                             input logic [7:0] y1, input logic [7:0] v);
        script_row_t row;
        row      = '{default: '0};
        row.beat = {y0, u, y1, v};
        return row;
    endfunction

    function automatic script_row_t checked_row(input logic [7:0] y0, input logic [7:0] u,
                                                input logic [7:0] y1, input logic [7:0] v,
                                                input logic [ADDR_W-1:0] address,
                                                input logic [PIX_W-1:0] first,
                                                input logic [PIX_W-1:0] second,
                                                input logic done);
        script_row_t row;
        row         = item_row(y0, u, y1, v);
        row.checked = 1'b1;
        row.result  = {address, first, second, done};
        return row;
    endfunction

    function automatic script_row_t register_row(input logic [CFG_IDX_W-1:0] index,
                                                 input logic [CFG_W-1:0] value);
        script_row_t row;
        row             = '{default: '0};
        row.is_register = 1'b1;
        row.index       = index;
        row.value       = value;
        return row;
    endfunction

    // mostly uniform, with a bias toward the byte extremes
    function automatic logic [7:0] random_byte();
        if ($urandom_range(0, 7) == 0)
            return $urandom_range(0, 1) ? 8'hff : 8'h00;
        return 8'($urandom);
    endfunction

    // small sizes keep frames short; now and then a value that needs clamping
    function automatic logic [CFG_W-1:0] random_dimension(input int upper);
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return CFG_W'($urandom_range(1, upper));
        endcase
    endfunction

    // ------------------------------------------------------------------
    // result checking
    // ------------------------------------------------------------------

    task automatic compare_field(input string name, input logic [ADDR_W-1:0] want,
                                 input logic [ADDR_W-1:0] got);
        if (want !== got)
        begin
            mismatches++;
            $display("@%0t rgb %s: expected %0h, got %0h", $time, name, want, got);
        end
    endtask

    // takes rgb beats in order and throttles the receiver
    always @(posedge clk)
    begin : rgb_sink
        rgb_beat_t want;
        if (rst_n && rgb_valid && !rgb_stall)
        begin
            if (framebuffer_writes.size() == 0)
            begin
                mismatches++;
                $display("@%0t rgb beat with nothing expected: expected none, got %h",
                         $time, rgb_data);
            end
            else
            begin
                want = framebuffer_writes.pop_front();
                compare_field("pixel_address", want.pixel_address, rgb_data.pixel_address);
                compare_field("first_pixel", ADDR_W'(want.first_pixel),
                              ADDR_W'(rgb_data.first_pixel));
                compare_field("second_pixel", ADDR_W'(want.second_pixel),
                              ADDR_W'(rgb_data.second_pixel));
                compare_field("frame_done", ADDR_W'(want.frame_done),
                              ADDR_W'(rgb_data.frame_done));
            end
        end
        rgb_stall <= rst_n && ($urandom_range(0, 99) < stall_pct);
    end

    // hang detector: counts cycles in which no channel moves a beat
    always @(posedge clk)
    begin
        if ((pix_valid && !pix_stall) || (rgb_valid && !rgb_stall) ||
            (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("yuyv_to_rgb565_framebuffer_writer_top_test: errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------

    initial
    begin
        // directed script, starting at the reset sizes of 800x600:
        // black and white at the start of the frame, then chroma extremes
        script.push_back(checked_row(8'h00, 8'h80, 8'h00, 8'h80, 24'd0, 16'h0000, 16'h0000, 1'b0));
        script.push_back(checked_row(8'hff, 8'h80, 8'hff, 8'h80, 24'd2, 16'hffff, 16'hffff, 1'b0));
        script.push_back(item_row(8'h00, 8'h00, 8'hff, 8'hff));
        script.push_back(item_row(8'hff, 8'hff, 8'h00, 8'h00));
        script.push_back(item_row(8'h80, 8'h00, 8'h80, 8'hff));
        script.push_back(item_row(8'h10, 8'hff, 8'heb, 8'h00));
        // shrink to a 2x1 image mid-line: the next beat closes the frame
        script.push_back(register_row(CFG_IMAGE_WIDTH, 13'd0));
        script.push_back(register_row(CFG_IMAGE_HEIGHT, 13'd0));
        script.push_back(checked_row(8'h00, 8'h80, 8'h00, 8'h80, 24'd12, 16'h0000, 16'h0000, 1'b1));
        // odd width 7 on a 4 pixel screen, two lines: half of each line is off screen
        script.push_back(register_row(CFG_IMAGE_WIDTH, 13'd7));
        script.push_back(register_row(CFG_SCREEN_WIDTH, 13'd4));
        script.push_back(register_row(CFG_IMAGE_HEIGHT, 13'd2));
        script.push_back(checked_row(8'h00, 8'h80, 8'h00, 8'h80, 24'd0, 16'h0000, 16'h0000, 1'b0));
        script.push_back(item_row(8'h51, 8'h5a, 8'hf0, 8'h0f));
        script.push_back(item_row(8'h29, 8'hf0, 8'h6e, 8'h6e));
        script.push_back(item_row(8'h91, 8'h36, 8'h10, 8'h22));
        script.push_back(item_row(8'hd2, 8'h10, 8'h92, 8'h01));
        script.push_back(item_row(8'h00, 8'hff, 8'hff, 8'h00));
        script.push_back(item_row(8'h7f, 8'h7f, 8'h80, 8'h80));
        script.push_back(item_row(8'hc4, 8'h92, 8'h3a, 8'hab));
        // all-ones registers clamp to the largest size; the unused index does nothing
        script.push_back(register_row(CFG_IMAGE_WIDTH, 13'h1fff));
        script.push_back(register_row(CFG_SCREEN_WIDTH, 13'h1fff));
        script.push_back(register_row(CFG_IMAGE_HEIGHT, 13'h1fff));
        script.push_back(register_row(CFG_UNUSED_INDEX, 13'h1fff));
        script.push_back(item_row(8'h55, 8'haa, 8'haa, 8'h55));
        script.push_back(item_row(8'haa, 8'h55, 8'h55, 8'haa));
        script.push_back(item_row(8'hff, 8'hff, 8'hff, 8'hff));

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        gap_pct   = GAP_BY_MODE[3];
        stall_pct = STALL_BY_MODE[3];
        foreach (script[i])
        begin
            if (script[i].is_register)
            begin
                drain_pipeline();
                write_register(script[i].index, script[i].value);
            end
            else
                send_macropixel(script[i].beat, script[i].checked, script[i].result);
        end

        // random phases: new sizes while a frame may be half done, random pixels,
        // each idle mode in turn
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            drain_pipeline();
            gap_pct   = GAP_BY_MODE[phase % 4];
            stall_pct = STALL_BY_MODE[phase % 4];
            write_register(CFG_IMAGE_WIDTH, random_dimension(24));
            write_register(CFG_SCREEN_WIDTH, random_dimension(28));
            write_register(CFG_IMAGE_HEIGHT, random_dimension(5));
            if ($urandom_range(0, 3) == 0)
                write_register(CFG_UNUSED_INDEX, CFG_W'($urandom));
            repeat (ITEMS_PER_PHASE)
                send_macropixel({random_byte(), random_byte(), random_byte(), random_byte()},
                                1'b0, '0);
        end

        drain_pipeline();
        if (mismatches == 0)
            $display("yuyv_to_rgb565_framebuffer_writer_top_test: clean");
        else
            $display("yuyv_to_rgb565_framebuffer_writer_top_test: errors");
        $finish;
    end

endmodule
